[design/stok_pkg.sv]
package stok_pkg;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_COMMENT = 3'd1;
    localparam logic [2:0] MODE_BLOCK   = 3'd2;
    localparam logic [2:0] MODE_NUMBER  = 3'd3;
    localparam logic [2:0] MODE_IDENT   = 3'd4;
    localparam logic [2:0] MODE_STRING  = 3'd5;

    localparam logic [5:0] K_ILLEGAL     = 6'd0;
    localparam logic [5:0] K_ERROR       = 6'd1;
    localparam logic [5:0] K_END         = 6'd2;
    localparam logic [5:0] K_INT         = 6'd3;
    localparam logic [5:0] K_FLOAT       = 6'd4;
    localparam logic [5:0] K_IDENT       = 6'd5;
    localparam logic [5:0] K_STRING      = 6'd6;
    localparam logic [5:0] K_SINGLE_BASE = 6'd7;
    localparam logic [5:0] K_UNDERSCORE  = 6'd30;
    localparam logic [5:0] K_DOUBLE_BASE = 6'd31;
    localparam logic [5:0] K_DDOTEQ      = 6'd47;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    typedef struct packed {
        logic [23:0] line_begin_pos;
        logic [23:0] line_number;
        logic [23:0] span_end;
        logic [23:0] span_start;
        logic [5:0]  kind;
    } token_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       dot;
    } scan_ctl_t;

    typedef struct packed {
        logic [1:0] len;
        logic       done;
        logic [1:0] ntok;
    } dec_res_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic [6:0] single_kind(input logic [7:0] c);
        logic [6:0] r;
        r = {1'b1, K_SINGLE_BASE};
        case (c)
            "+": r[5:0] = K_SINGLE_BASE + 6'd0;
            "-": r[5:0] = K_SINGLE_BASE + 6'd1;
            "*": r[5:0] = K_SINGLE_BASE + 6'd2;
            "/": r[5:0] = K_SINGLE_BASE + 6'd3;
            "(": r[5:0] = K_SINGLE_BASE + 6'd4;
            ")": r[5:0] = K_SINGLE_BASE + 6'd5;
            "{": r[5:0] = K_SINGLE_BASE + 6'd6;
            "}": r[5:0] = K_SINGLE_BASE + 6'd7;
            "[": r[5:0] = K_SINGLE_BASE + 6'd8;
            "]": r[5:0] = K_SINGLE_BASE + 6'd9;
            ";": r[5:0] = K_SINGLE_BASE + 6'd10;
            ",": r[5:0] = K_SINGLE_BASE + 6'd11;
            ".": r[5:0] = K_SINGLE_BASE + 6'd12;
            ":": r[5:0] = K_SINGLE_BASE + 6'd13;
            "=": r[5:0] = K_SINGLE_BASE + 6'd14;
            "<": r[5:0] = K_SINGLE_BASE + 6'd15;
            ">": r[5:0] = K_SINGLE_BASE + 6'd16;
            "!": r[5:0] = K_SINGLE_BASE + 6'd17;
            "&": r[5:0] = K_SINGLE_BASE + 6'd18;
            "|": r[5:0] = K_SINGLE_BASE + 6'd19;
            "%": r[5:0] = K_SINGLE_BASE + 6'd20;
            "@": r[5:0] = K_SINGLE_BASE + 6'd21;
            "?": r[5:0] = K_SINGLE_BASE + 6'd22;
            "_": r[5:0] = K_UNDERSCORE;
            default: r = {1'b0, K_ILLEGAL};
        endcase
        return r;
    endfunction

    function automatic logic [6:0] double_kind(input logic [7:0] c, input logic [7:0] n);
        logic [6:0] r;
        r = {1'b1, K_DOUBLE_BASE};
        case ({c, n})
            "&&": r[5:0] = K_DOUBLE_BASE + 6'd0;
            "||": r[5:0] = K_DOUBLE_BASE + 6'd1;
            "+=": r[5:0] = K_DOUBLE_BASE + 6'd2;
            "-=": r[5:0] = K_DOUBLE_BASE + 6'd3;
            "*=": r[5:0] = K_DOUBLE_BASE + 6'd4;
            "/=": r[5:0] = K_DOUBLE_BASE + 6'd5;
            "%=": r[5:0] = K_DOUBLE_BASE + 6'd6;
            "<=": r[5:0] = K_DOUBLE_BASE + 6'd7;
            ">=": r[5:0] = K_DOUBLE_BASE + 6'd8;
            ">>": r[5:0] = K_DOUBLE_BASE + 6'd9;
            "!=": r[5:0] = K_DOUBLE_BASE + 6'd10;
            "==": r[5:0] = K_DOUBLE_BASE + 6'd11;
            "->": r[5:0] = K_DOUBLE_BASE + 6'd12;
            "=>": r[5:0] = K_DOUBLE_BASE + 6'd13;
            "..": r[5:0] = K_DOUBLE_BASE + 6'd14;
            "::": r[5:0] = K_DOUBLE_BASE + 6'd15;
            default: r = {1'b0, K_ILLEGAL};
        endcase
        return r;
    endfunction

endpackage

[design/stok_decide.sv]
module stok_decide
    import stok_pkg::*;
#(
    parameter int PW = 24
)
(
    input  scan_ctl_t         ctl_i,
    input  logic [7:0]        c,
    input  logic [7:0]        n,
    input  logic [7:0]        nn,
    input  logic [PW-1:0]     pos,
    input  logic [PW-1:0]     line,
    input  logic [PW-1:0]     lstart,
    input  logic [PW-1:0]     tbeg_i,
    input  logic [PW-1:0]     tline_i,
    input  logic [PW-1:0]     tlstart_i,
    output scan_ctl_t         ctl_o,
    output logic [PW-1:0]     tbeg_o,
    output logic [PW-1:0]     tline_o,
    output logic [PW-1:0]     tlstart_o,
    output dec_res_t          res,
    output token_t            tok0,
    output token_t            tok1
);

    localparam logic [PW-1:0] PMAX = '1;

    token_t     t [2];
    logic [1:0] nt;
    logic       idle_go;
    logic [6:0] sk;
    logic [6:0] dk;

    function automatic logic [PW-1:0] sat_add(input logic [PW-1:0] v, input logic [1:0] d);
        logic [PW:0] s;
        s = {1'b0, v} + {{(PW-1){1'b0}}, d};
        return s[PW] ? PMAX : s[PW-1:0];
    endfunction

    function automatic token_t mk(input logic [5:0] kind, input logic [PW-1:0] s,
                                  input logic [PW-1:0] e, input logic [PW-1:0] ln,
                                  input logic [PW-1:0] ls);
        token_t r;
        r.kind           = kind;
        r.span_start     = 24'(s);
        r.span_end       = 24'(e);
        r.line_number    = 24'(ln);
        r.line_begin_pos = 24'(ls);
        return r;
    endfunction

    always_comb
    begin
        sk        = single_kind(c);
        dk        = double_kind(c, n);
        ctl_o     = ctl_i;
        tbeg_o    = tbeg_i;
        tline_o   = tline_i;
        tlstart_o = tlstart_i;
        res       = '0;
        nt        = 2'd0;
        t[0]      = '0;
        t[1]      = '0;
        idle_go   = 1'b0;
        case (ctl_i.mode)
            MODE_COMMENT:
            begin
                if (c != CH_LF && c != CH_NUL)
                    res.len = 2'd1;
                else
                    idle_go = 1'b1;
            end
            MODE_BLOCK:
            begin
                if (c == CH_NUL)
                begin
                    t[nt[0]] = mk(K_ERROR, tbeg_i, pos, line, lstart);
                    nt = nt + 2'd1;
                    idle_go = 1'b1;
                end
                else if (c == CH_STAR && n == CH_MINUS)
                begin
                    ctl_o.mode = MODE_IDLE;
                    res.len = 2'd2;
                end
                else
                    res.len = 2'd1;
            end
            MODE_NUMBER:
            begin
                if (is_digit(c))
                    res.len = 2'd1;
                else if (c == CH_DOT && n != CH_DOT && !ctl_i.dot)
                begin
                    ctl_o.dot = 1'b1;
                    res.len = 2'd1;
                end
                else
                begin
                    t[nt[0]] = mk(ctl_i.dot ? K_FLOAT : K_INT, tbeg_i, pos, tline_i, tlstart_i);
                    nt = nt + 2'd1;
                    idle_go = 1'b1;
                end
            end
            MODE_IDENT:
            begin
                if (is_alnum(c) || c == CH_UNDER)
                    res.len = 2'd1;
                else
                begin
                    t[nt[0]] = mk(K_IDENT, tbeg_i, pos, tline_i, tlstart_i);
                    nt = nt + 2'd1;
                    idle_go = 1'b1;
                end
            end
            MODE_STRING:
            begin
                if (c == CH_QUOTE)
                begin
                    t[nt[0]] = mk(K_STRING, sat_add(tbeg_i, 2'd1), pos, tline_i, tlstart_i);
                    nt = nt + 2'd1;
                    ctl_o.mode = MODE_IDLE;
                    res.len = 2'd1;
                end
                else if (c == CH_NUL)
                begin
                    t[nt[0]] = mk(K_ILLEGAL, tbeg_i, pos, tline_i, tlstart_i);
                    nt = nt + 2'd1;
                    idle_go = 1'b1;
                end
                else if (c == CH_BSLASH && n == CH_QUOTE)
                    res.len = 2'd2;
                else
                    res.len = 2'd1;
            end
            default:
                idle_go = 1'b1;
        endcase

        if (idle_go)
        begin
            ctl_o.mode = MODE_IDLE;
            if (c == CH_SP || c == CH_TAB || c == CH_LF)
                res.len = 2'd1;
            else if (c == CH_MINUS && n == CH_MINUS)
            begin
                ctl_o.mode = MODE_COMMENT;
                res.len = 2'd2;
            end
            else if (c == CH_MINUS && n == CH_STAR)
            begin
                ctl_o.mode = MODE_BLOCK;
                tbeg_o = pos;
                tline_o = line;
                tlstart_o = lstart;
                res.len = 2'd2;
            end
            else if (is_digit(c) || (c == CH_DOT && is_digit(n)))
            begin
                ctl_o.mode = MODE_NUMBER;
                ctl_o.dot = (c == CH_DOT);
                tbeg_o = pos;
                tline_o = line;
                tlstart_o = lstart;
                res.len = 2'd1;
            end
            else if (c == CH_UNDER && !is_alnum(n))
            begin
                t[nt[0]] = mk(K_UNDERSCORE, pos, sat_add(pos, 2'd1), line, lstart);
                nt = nt + 2'd1;
                res.len = 2'd1;
            end
            else if (is_alnum(c) || c == CH_UNDER)
            begin
                ctl_o.mode = MODE_IDENT;
                tbeg_o = pos;
                tline_o = line;
                tlstart_o = lstart;
                res.len = 2'd1;
            end
            else if (c == CH_QUOTE)
            begin
                ctl_o.mode = MODE_STRING;
                tbeg_o = pos;
                tline_o = line;
                tlstart_o = lstart;
                res.len = 2'd1;
            end
            else if (c == CH_NUL)
            begin
                t[nt[0]] = mk(K_END, pos, pos, line, lstart);
                nt = nt + 2'd1;
                res.done = 1'b1;
            end
            else if (c == CH_DOT && n == CH_DOT && nn == CH_EQ)
            begin
                t[nt[0]] = mk(K_DDOTEQ, pos, sat_add(pos, 2'd3), line, lstart);
                nt = nt + 2'd1;
                res.len = 2'd3;
            end
            else if (dk[6])
            begin
                t[nt[0]] = mk(dk[5:0], pos, sat_add(pos, 2'd2), line, lstart);
                nt = nt + 2'd1;
                res.len = 2'd2;
            end
            else
            begin
                t[nt[0]] = mk(sk[6] ? sk[5:0] : K_ILLEGAL, pos, sat_add(pos, 2'd1), line,
                              lstart);
                nt = nt + 2'd1;
                res.len = 2'd1;
            end
        end
        res.ntok = nt;
    end

    assign tok0 = t[0];
    assign tok1 = t[1];

endmodule

[design/source_tokenizer_unit.sv]
// A token is stored in the slot registers when its word is accepted, and is then
// loaded into the output register. Throughput: one source byte per cycle while m_axis
// is not stalled; a byte with more than one token holds the input while they drain.
// Reset: rst_n clears scan state, lookahead, position counters and the output side;
// the scan also returns to reset state after each word that ends the source.
module source_tokenizer_unit
    import stok_pkg::*;
#(
    parameter int POSITION_BITS = 24
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // ch
    input  logic         s_axis_tlast,   // end_of_source
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // token_kind, span_start, span_end, line_number,
                                         // line_begin_pos
    output logic         m_axis_tlast    // last_of_run
);

    localparam int PW = POSITION_BITS;
    localparam logic [PW-1:0] PMAX = '1;

    typedef struct packed {
        logic [PW-1:0] pos;
        logic [PW-1:0] line;
        logic [PW-1:0] lstart;
    } cursor_t;

    function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
        return (v == PMAX) ? PMAX : v + 1'b1;
    endfunction

    function automatic cursor_t consume1(input cursor_t cur, input logic [7:0] b);
        cursor_t r;
        r = cur;
        r.pos = sat_inc(cur.pos);
        if (b == CH_LF)
        begin
            r.line = sat_inc(cur.line);
            r.lstart = r.pos;
        end
        return r;
    endfunction

    cursor_t       cur_reg;
    scan_ctl_t     ctl_reg;
    logic [PW-1:0] tbeg_reg;
    logic [PW-1:0] tline_reg;
    logic [PW-1:0] tlstart_reg;
    logic [7:0]    la0_reg;
    logic [7:0]    la1_reg;
    logic [1:0]    la_cnt_reg;

    token_t        slots_reg [4];
    logic [2:0]    rem_reg;
    logic [1:0]    rd_reg;
    token_t        out_reg;
    logic          out_last_reg;
    logic          out_valid_reg;

    logic          acc;
    logic          ends;
    logic          out_load;
    logic [7:0]    b;
    logic [7:0]    w0;
    logic [7:0]    w1;
    cursor_t       cur_a;
    cursor_t       cur_b;
    cursor_t       cur_c;
    cursor_t       cur1;
    cursor_t       cur2;
    cursor_t       cur_next;
    logic [1:0]    idx1;
    logic [2:0]    sum2;
    logic [1:0]    idx2;
    logic [7:0]    c0, n0, nn0, c1, n1, c2;

    scan_ctl_t     ctl0, ctl1, ctl2;
    logic [PW-1:0] tb0, tl0, ts0, tb1, tl1, ts1, tb2, tl2, ts2;
    dec_res_t      r0, r1, r2;
    token_t        t00, t01, t10, t11, t20, t21;

    token_t        cand [6];
    logic [5:0]    cand_v;
    token_t        new_slots [4];
    logic [2:0]    new_cnt;

    assign b    = s_axis_tdata;
    assign ends = s_axis_tlast || (s_axis_tdata == CH_NUL);
    assign w0   = (la_cnt_reg != 2'd0) ? la0_reg : CH_NUL;
    assign w1   = (la_cnt_reg == 2'd2) ? la1_reg : CH_NUL;

    assign c0  = ends ? w0 : la0_reg;
    assign n0  = ends ? w1 : la1_reg;
    assign nn0 = ends ? CH_NUL : b;

    assign cur_a = consume1(cur_reg, la0_reg);
    assign cur_b = consume1(cur_a, la1_reg);
    assign cur_c = consume1(cur_b, b);

    stok_decide #(.PW(PW)) u_dec0 (
        .ctl_i(ctl_reg), .c(c0), .n(n0), .nn(nn0),
        .pos(cur_reg.pos), .line(cur_reg.line), .lstart(cur_reg.lstart),
        .tbeg_i(tbeg_reg), .tline_i(tline_reg), .tlstart_i(tlstart_reg),
        .ctl_o(ctl0), .tbeg_o(tb0), .tline_o(tl0), .tlstart_o(ts0),
        .res(r0), .tok0(t00), .tok1(t01)
    );

    always_comb
    begin
        idx1 = (r0.len > la_cnt_reg) ? la_cnt_reg : r0.len;
        sum2 = {1'b0, idx1} + {1'b0, r1.len};
        idx2 = (sum2 > {1'b0, la_cnt_reg}) ? la_cnt_reg : sum2[1:0];
        case (idx1)
            2'd0:
            begin
                cur1 = cur_reg;
                c1 = w0;
                n1 = w1;
            end
            2'd1:
            begin
                cur1 = cur_a;
                c1 = w1;
                n1 = CH_NUL;
            end
            default:
            begin
                cur1 = cur_b;
                c1 = CH_NUL;
                n1 = CH_NUL;
            end
        endcase
        case (idx2)
            2'd0:
            begin
                cur2 = cur_reg;
                c2 = w0;
            end
            2'd1:
            begin
                cur2 = cur_a;
                c2 = w1;
            end
            default:
            begin
                cur2 = cur_b;
                c2 = CH_NUL;
            end
        endcase
    end

    stok_decide #(.PW(PW)) u_dec1 (
        .ctl_i(ctl0), .c(c1), .n(n1), .nn(CH_NUL),
        .pos(cur1.pos), .line(cur1.line), .lstart(cur1.lstart),
        .tbeg_i(tb0), .tline_i(tl0), .tlstart_i(ts0),
        .ctl_o(ctl1), .tbeg_o(tb1), .tline_o(tl1), .tlstart_o(ts1),
        .res(r1), .tok0(t10), .tok1(t11)
    );

    stok_decide #(.PW(PW)) u_dec2 (
        .ctl_i(ctl1), .c(c2), .n(CH_NUL), .nn(CH_NUL),
        .pos(cur2.pos), .line(cur2.line), .lstart(cur2.lstart),
        .tbeg_i(tb1), .tline_i(tl1), .tlstart_i(ts1),
        .ctl_o(ctl2), .tbeg_o(tb2), .tline_o(tl2), .tlstart_o(ts2),
        .res(r2), .tok0(t20), .tok1(t21)
    );

    always_comb
    begin
        cand[0] = t00;
        cand[1] = t01;
        cand[2] = t10;
        cand[3] = t11;
        cand[4] = t20;
        cand[5] = t21;
        cand_v  = '0;
        if (ends || la_cnt_reg == 2'd2)
        begin
            cand_v[0] = (r0.ntok != 2'd0);
            cand_v[1] = (r0.ntok == 2'd2);
        end
        if (ends && !r0.done)
        begin
            cand_v[2] = (r1.ntok != 2'd0);
            cand_v[3] = (r1.ntok == 2'd2);
            if (!r1.done)
            begin
                cand_v[4] = (r2.ntok != 2'd0);
                cand_v[5] = (r2.ntok == 2'd2);
            end
        end
        for (int i = 0; i < 4; i++)
            new_slots[i] = '0;
        new_cnt = 3'd0;
        for (int i = 0; i < 6; i++)
        begin
            if (cand_v[i] && new_cnt != 3'd4)
            begin
                new_slots[new_cnt[1:0]] = cand[i];
                new_cnt = new_cnt + 3'd1;
            end
        end
    end

    always_comb
    begin
        case (r0.len)
            2'd1:    cur_next = cur_a;
            2'd2:    cur_next = cur_b;
            2'd3:    cur_next = cur_c;
            default: cur_next = cur_reg;
        endcase
    end

    assign out_load      = (rem_reg != 3'd0) && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = (rem_reg == 3'd0) || ((rem_reg == 3'd1) && out_load);
    assign acc           = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg.pos    <= '0;
            cur_reg.line   <= {{(PW-1){1'b0}}, 1'b1};
            cur_reg.lstart <= '0;
            ctl_reg        <= '{mode: MODE_IDLE, dot: 1'b0};
            tbeg_reg       <= '0;
            tline_reg      <= '0;
            tlstart_reg    <= '0;
            la0_reg        <= '0;
            la1_reg        <= '0;
            la_cnt_reg     <= 2'd0;
        end
        else if (acc)
        begin
            if (ends)
            begin
                cur_reg.pos    <= '0;
                cur_reg.line   <= {{(PW-1){1'b0}}, 1'b1};
                cur_reg.lstart <= '0;
                ctl_reg        <= '{mode: MODE_IDLE, dot: 1'b0};
                tbeg_reg       <= '0;
                tline_reg      <= '0;
                tlstart_reg    <= '0;
                la0_reg        <= '0;
                la1_reg        <= '0;
                la_cnt_reg     <= 2'd0;
            end
            else if (la_cnt_reg != 2'd2)
            begin
                if (la_cnt_reg == 2'd0)
                    la0_reg <= b;
                else
                    la1_reg <= b;
                la_cnt_reg <= la_cnt_reg + 2'd1;
            end
            else
            begin
                cur_reg     <= cur_next;
                ctl_reg     <= ctl0;
                tbeg_reg    <= tb0;
                tline_reg   <= tl0;
                tlstart_reg <= ts0;
                case (r0.len)
                    2'd1:
                    begin
                        la0_reg    <= la1_reg;
                        la1_reg    <= b;
                        la_cnt_reg <= 2'd2;
                    end
                    2'd2:
                    begin
                        la0_reg    <= b;
                        la_cnt_reg <= 2'd1;
                    end
                    default:
                        la_cnt_reg <= 2'd0;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= 3'd0;
            rd_reg        <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                rem_reg <= new_cnt;
                rd_reg  <= 2'd0;
            end
            else if (out_load)
            begin
                rem_reg <= rem_reg - 3'd1;
                rd_reg  <= rd_reg + 2'd1;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            slots_reg <= new_slots;
        if (out_load)
        begin
            out_reg      <= slots_reg[rd_reg];
            out_last_reg <= (rem_reg == 3'd1);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

[tb/sv/tb.sv]
module tb;
    import stok_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned POS_LIMIT = (64'd1 << 24) - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BYTES = 290;

    typedef struct {
        token_t tok;
        logic   last;
    } tok_entry_t;

    typedef struct {
        logic [7:0] ch;
        logic       eos;
        int         ntyped;
        token_t     t0;
        token_t     t1;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;
    logic         m_axis_tlast;

    tok_entry_t pending_tokens[$];
    token_t     step_tokens[$];
    int         errors = 0;
    int         cycles = 0;
    int         burst_left = 0;

    logic [2:0]      sc_mode;
    logic [7:0]      la_bytes[2];
    int              la_cnt;
    longint unsigned pos, cur_line, cur_lstart, tk_begin, tk_line, tk_lstart;
    logic            dot_seen;
    logic            end_hit;

    string single_chars = "+-*/(){}[];,.:=<>!&|%@?_";
    string double_pairs[16] = '{"&&", "||", "+=", "-=", "*=", "/=", "%=", "<=", ">=", ">>",
                                "!=", "==", "->", "=>", "..", "::"};

    source_tokenizer_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic token_t mk_tok(logic [5:0] kind, logic [23:0] s, logic [23:0] e,
                                      logic [23:0] ln, logic [23:0] lb);
        token_t t;
        t.kind = kind;
        t.span_start = s;
        t.span_end = e;
        t.line_number = ln;
        t.line_begin_pos = lb;
        return t;
    endfunction

    function automatic longint unsigned sat_add(longint unsigned v, longint unsigned d);
        return (v >= POS_LIMIT || POS_LIMIT - v < d) ? POS_LIMIT : v + d;
    endfunction

    function automatic logic digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic alnum(logic [7:0] c);
        return digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function void push_tok(logic [5:0] kind, longint unsigned s, longint unsigned e,
                           longint unsigned ln, longint unsigned lb);
        if (step_tokens.size() < 4)
            step_tokens.push_back(mk_tok(kind, s[23:0], e[23:0], ln[23:0], lb[23:0]));
    endfunction

    function void clear_scan();
        sc_mode = MODE_IDLE;
        la_bytes[0] = 8'h00;
        la_bytes[1] = 8'h00;
        la_cnt = 0;
        pos = 0;
        cur_line = 1;
        cur_lstart = 0;
        tk_begin = 0;
        tk_line = 0;
        tk_lstart = 0;
        dot_seen = 1'b0;
    endfunction

    function void open_token(logic [2:0] m);
        sc_mode = m;
        tk_begin = pos;
        tk_line = cur_line;
        tk_lstart = cur_lstart;
    endfunction

    function void advance(logic [7:0] c);
        pos = sat_add(pos, 1);
        if (c == CH_LF)
        begin
            cur_line = sat_add(cur_line, 1);
            cur_lstart = pos;
        end
    endfunction

    function int scan_decide(logic [7:0] c, logic [7:0] n, logic [7:0] nn);
        case (sc_mode)
            MODE_COMMENT:
                if (c != CH_LF && c != CH_NUL)
                    return 1;
            MODE_BLOCK:
            begin
                if (c == CH_NUL)
                    push_tok(K_ERROR, tk_begin, pos, cur_line, cur_lstart);
                else if (c == CH_STAR && n == CH_MINUS)
                begin
                    sc_mode = MODE_IDLE;
                    return 2;
                end
                else
                    return 1;
            end
            MODE_NUMBER:
            begin
                if (digit(c))
                    return 1;
                if (c == CH_DOT && n != CH_DOT && !dot_seen)
                begin
                    dot_seen = 1'b1;
                    return 1;
                end
                push_tok(dot_seen ? K_FLOAT : K_INT, tk_begin, pos, tk_line, tk_lstart);
            end
            MODE_IDENT:
            begin
                if (alnum(c) || c == CH_UNDER)
                    return 1;
                push_tok(K_IDENT, tk_begin, pos, tk_line, tk_lstart);
            end
            MODE_STRING:
            begin
                if (c == CH_QUOTE)
                begin
                    push_tok(K_STRING, sat_add(tk_begin, 1), pos, tk_line, tk_lstart);
                    sc_mode = MODE_IDLE;
                    return 1;
                end
                if (c == CH_NUL)
                    push_tok(K_ILLEGAL, tk_begin, pos, tk_line, tk_lstart);
                else if (c == CH_BSLASH && n == CH_QUOTE)
                    return 2;
                else
                    return 1;
            end
            default: ;
        endcase
        sc_mode = MODE_IDLE;

        if (c == CH_SP || c == CH_TAB || c == CH_LF)
            return 1;
        if (c == CH_MINUS && n == CH_MINUS)
        begin
            sc_mode = MODE_COMMENT;
            return 2;
        end
        if (c == CH_MINUS && n == CH_STAR)
        begin
            open_token(MODE_BLOCK);
            return 2;
        end
        if (digit(c) || (c == CH_DOT && digit(n)))
        begin
            open_token(MODE_NUMBER);
            dot_seen = (c == CH_DOT);
            return 1;
        end
        if (c == CH_UNDER && !alnum(n))
        begin
            push_tok(K_UNDERSCORE, pos, sat_add(pos, 1), cur_line, cur_lstart);
            return 1;
        end
        if (alnum(c) || c == CH_UNDER)
        begin
            open_token(MODE_IDENT);
            return 1;
        end
        if (c == CH_QUOTE)
        begin
            open_token(MODE_STRING);
            return 1;
        end
        if (c == CH_NUL)
        begin
            push_tok(K_END, pos, pos, cur_line, cur_lstart);
            clear_scan();
            end_hit = 1'b1;
            return 0;
        end
        if (c == CH_DOT && n == CH_DOT && nn == CH_EQ)
        begin
            push_tok(K_DDOTEQ, pos, sat_add(pos, 3), cur_line, cur_lstart);
            return 3;
        end
        for (int i = 0; i < 16; i++)
            if (c == double_pairs[i][0] && n == double_pairs[i][1])
            begin
                push_tok(K_DOUBLE_BASE + 6'(i), pos, sat_add(pos, 2), cur_line, cur_lstart);
                return 2;
            end
        for (int i = 0; i < 24; i++)
            if (c == single_chars[i])
            begin
                push_tok(K_SINGLE_BASE + 6'(i), pos, sat_add(pos, 1), cur_line, cur_lstart);
                return 1;
            end
        push_tok(K_ILLEGAL, pos, sat_add(pos, 1), cur_line, cur_lstart);
        return 1;
    endfunction

    function void scan_byte(logic [7:0] ch, logic eos);
        logic [7:0] w[5];
        int         k, cnt, idx;
        step_tokens.delete();
        end_hit = 1'b0;
        cnt = la_cnt;
        for (int i = 0; i < 5; i++)
            w[i] = 8'h00;
        for (int i = 0; i < cnt; i++)
            w[i] = la_bytes[i];
        if (!(eos || ch == CH_NUL))
        begin
            if (cnt < 2)
            begin
                la_bytes[cnt] = ch;
                la_cnt = cnt + 1;
                return;
            end
            w[2] = ch;
            k = scan_decide(w[0], w[1], w[2]);
            for (int i = 0; i < k; i++)
                advance(w[i]);
            la_cnt = 0;
            for (int i = k; i < 3; i++)
            begin
                la_bytes[la_cnt] = w[i];
                la_cnt++;
            end
        end
        else
        begin
            idx = 0;
            for (int i = 0; i < 12 && !end_hit; i++)
            begin
                k = scan_decide(w[idx], w[idx + 1], w[idx + 2]);
                if (end_hit)
                    break;
                while (k > 0 && idx < cnt)
                begin
                    advance(w[idx]);
                    idx++;
                    k--;
                end
            end
        end
    endfunction

    function void queue_tokens(token_t toks[$]);
        tok_entry_t e;
        foreach (toks[i])
        begin
            e.tok = toks[i];
            e.last = (i == toks.size() - 1);
            pending_tokens.push_back(e);
        end
    endfunction

    task automatic send_word(logic [7:0] ch, logic eos, int ntyped = 0,
                             token_t t0 = '0, token_t t1 = '0);
        token_t typed[$];
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 6))
                begin
                    @(negedge clk);
                    s_axis_tvalid <= 1'b0;
                end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ch;
        s_axis_tlast <= eos;
        do
            @(posedge clk);
        while (!s_axis_tready);
        scan_byte(ch, eos);
        if (ntyped > 0)
        begin
            typed.push_back(t0);
            if (ntyped > 1)
                typed.push_back(t1);
            queue_tokens(typed);
        end
        else
            queue_tokens(step_tokens);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    task automatic drain_tokens();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // receiver stall pattern: pick a new style and pattern when the current run ends
    initial
    begin
        int          style;
        int          left;
        logic [15:0] pat;
        style = 0;
        left = 0;
        pat = 16'hB3C5;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                style = $urandom_range(0, 3);
                left = $urandom_range(40, 300);
                pat = 16'($urandom_range(1, 65535));
            end
            left--;
            pat = {pat[14:0], pat[15]};
            case (style)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 9) < 7);
                2: m_axis_tready <= pat[0];
                default: m_axis_tready <= ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    always @(posedge clk)
    begin
        tok_entry_t e;
        token_t     got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[101:0];
            if (pending_tokens.size() == 0)
            begin
                $display("%0t: unexpected word kind=%0d tdata=%h", $time, got.kind,
                         m_axis_tdata);
                errors++;
            end
            else
            begin
                e = pending_tokens.pop_front();
                if (got.kind != e.tok.kind)
                begin
                    $display("%0t: kind expected %0d actual %0d", $time, e.tok.kind, got.kind);
                    errors++;
                end
                if (got.span_start != e.tok.span_start)
                begin
                    $display("%0t: span_start expected %0d actual %0d", $time,
                             e.tok.span_start, got.span_start);
                    errors++;
                end
                if (got.span_end != e.tok.span_end)
                begin
                    $display("%0t: span_end expected %0d actual %0d", $time,
                             e.tok.span_end, got.span_end);
                    errors++;
                end
                if (got.line_number != e.tok.line_number)
                begin
                    $display("%0t: line_number expected %0d actual %0d", $time,
                             e.tok.line_number, got.line_number);
                    errors++;
                end
                if (got.line_begin_pos != e.tok.line_begin_pos)
                begin
                    $display("%0t: line_begin_pos expected %0d actual %0d", $time,
                             e.tok.line_begin_pos, got.line_begin_pos);
                    errors++;
                end
                if (m_axis_tlast != e.last)
                begin
                    $display("%0t: tlast expected %0b actual %0b", $time, e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t rows[$];
        string     idents[4] = '{"abc", "_x1", "Zeta_9", "q"};
        string     numbers[6] = '{"0", "42", "3.14", ".5", "7..9", "1.2.3"};
        string     strs[4] = '{"\"hi\"", "\"a\\\"b\"", "\"\"", "\"x\ny\""};
        string     notes[4] = '{"-- note", "--- doc", "-* blk *-", "-*\n*-"};
        string     spaces[4] = '{" ", "\t", "\n", "  \n"};
        string     ops[41];
        int        sent;
        int        first;

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tlast = 1'b0;
        clear_scan();
        for (int i = 0; i < 24; i++)
            ops[i] = string'(single_chars[i]);
        for (int i = 0; i < 16; i++)
            ops[24 + i] = double_pairs[i];
        ops[40] = "..=";

        rows.push_back('{8'h00, 1'b1, 1, mk_tok(K_END, 24'd0, 24'd0, 24'd1, 24'd0), '0});
        rows.push_back('{CH_MINUS, 1'b0, 0, '0, '0});
        rows.push_back('{CH_STAR, 1'b0, 0, '0, '0});
        rows.push_back('{8'h41, 1'b1, 2, mk_tok(K_ERROR, 24'd0, 24'd2, 24'd1, 24'd0),
                         mk_tok(K_END, 24'd2, 24'd2, 24'd1, 24'd0)});
        rows.push_back('{8'hFF, 1'b0, 0, '0, '0});
        rows.push_back('{"_", 1'b0, 0, '0, '0});
        rows.push_back('{CH_SP, 1'b0, 0, '0, '0});
        rows.push_back('{"x", 1'b0, 0, '0, '0});
        rows.push_back('{CH_LF, 1'b0, 0, '0, '0});
        rows.push_back('{CH_DOT, 1'b0, 0, '0, '0});
        rows.push_back('{CH_DOT, 1'b0, 0, '0, '0});
        rows.push_back('{CH_EQ, 1'b0, 0, '0, '0});
        rows.push_back('{".", 1'b0, 0, '0, '0});
        rows.push_back('{"5", 1'b0, 0, '0, '0});
        rows.push_back('{".", 1'b0, 0, '0, '0});
        rows.push_back('{".", 1'b0, 0, '0, '0});
        rows.push_back('{"9", 1'b0, 0, '0, '0});
        rows.push_back('{"\"", 1'b0, 0, '0, '0});
        rows.push_back('{"\\", 1'b0, 0, '0, '0});
        rows.push_back('{"\"", 1'b0, 0, '0, '0});
        rows.push_back('{8'h80, 1'b0, 0, '0, '0});
        rows.push_back('{8'h00, 1'b0, 0, '0, '0});
        rows.push_back('{8'h7F, 1'b0, 0, '0, '0});
        rows.push_back('{8'hFF, 1'b1, 0, '0, '0});

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
            send_word(rows[i].ch, rows[i].eos, rows[i].ntyped, rows[i].t0, rows[i].t1);

        sent = 0;
        first = 1;
        while (sent < RANDOM_BYTES)
        begin
            string src;
            int    r;
            src = "";
            repeat ($urandom_range(1, 8))
            begin
                case ($urandom_range(0, 9))
                    0: src = {src, idents[$urandom_range(0, 3)]};
                    1: src = {src, numbers[$urandom_range(0, 5)]};
                    2: src = {src, strs[$urandom_range(0, 3)]};
                    3: src = {src, notes[$urandom_range(0, 3)]};
                    4: src = {src, spaces[$urandom_range(0, 3)]};
                    8: src = {src, string'(8'($urandom_range(1, 255)))};
                    9: src = {src, "\n"};
                    default: src = {src, ops[$urandom_range(0, 40)]};
                endcase
                if ($urandom_range(0, 1) == 0)
                    src = {src, " "};
            end
            r = $urandom_range(0, 9);
            if (r == 0)
                src = {src, "\"ab\nc"};
            else if (r == 1)
                src = {src, "-* x\n"};
            send_text(src);
            if ($urandom_range(0, 3) == 0)
                send_word(8'h00, 1'b0);
            else
                send_word(8'($urandom_range(0, 255)), 1'b1);
            sent += src.len() + 1;
            if (first || $urandom_range(0, 7) == 0)
                drain_tokens();
            first = 0;
        end

        drain_tokens();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
